@@ src/crtc_pkg.sv @@
// Package with commands, register indexes and shared types of the raster timing controller.
`default_nettype none
package crtc_pkg;

    localparam int AddrBits = 14;

    typedef enum logic [2:0] {
        CMD_CHAR   = 3'd0,
        CMD_FRAME  = 3'd1,
        CMD_SELECT = 3'd2,
        CMD_WRITE  = 3'd3,
        CMD_READ   = 3'd4,
        CMD_LOAD   = 3'd5
    } cmd_t;

    localparam logic [4:0] REG_HTOTAL   = 5'd0;
    localparam logic [4:0] REG_HDISP    = 5'd1;
    localparam logic [4:0] REG_HSPOS    = 5'd2;
    localparam logic [4:0] REG_SYNCW    = 5'd3;
    localparam logic [4:0] REG_VTOTAL   = 5'd4;
    localparam logic [4:0] REG_VADJ     = 5'd5;
    localparam logic [4:0] REG_VDISP    = 5'd6;
    localparam logic [4:0] REG_VSPOS    = 5'd7;
    localparam logic [4:0] REG_MODE     = 5'd8;
    localparam logic [4:0] REG_MAXLINE  = 5'd9;
    localparam logic [4:0] REG_CURSTART = 5'd10;
    localparam logic [4:0] REG_CUREND   = 5'd11;
    localparam logic [4:0] REG_STARTH   = 5'd12;
    localparam logic [4:0] REG_STARTL   = 5'd13;
    localparam logic [4:0] REG_CURH     = 5'd14;
    localparam logic [4:0] REG_CURL     = 5'd15;
    localparam logic [4:0] REG_PENH     = 5'd16;
    localparam logic [4:0] REG_PENL     = 5'd17;

    localparam logic [5:0] BlinkWrap  = 6'd49;
    localparam logic [5:0] BlinkHalf  = 6'd25;
    localparam logic [6:0] CurModeMsk = 7'h60;
    localparam logic [6:0] CurModeOff = 7'h20;

    // Result of one transaction.
    typedef struct packed {
        logic [13:0] char_address;
        logic [4:0]  row_address;
        logic        hsync;
        logic        vsync;
        logic        display_enable;
        logic        cursor;
        logic        blink_phase;
        logic [7:0]  read_data;
    } result_t;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [13:0] data;
    } item_t;

endpackage
`default_nettype wire

@@ src/crtc_if.sv @@
// Valid/ready channel interfaces of the raster timing controller.
`default_nettype none
interface crtc_item_if;
    import crtc_pkg::*;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [13:0] data;
    modport source (output valid, output cmd, output data, input ready);
    modport sink (input valid, input cmd, input data, output ready);
endinterface

interface crtc_result_if;
    logic        valid;
    logic        ready;
    logic [13:0] char_address;
    logic [4:0]  row_address;
    logic        hsync;
    logic        vsync;
    logic        display_enable;
    logic        cursor;
    logic        blink_phase;
    logic [7:0]  read_data;
    modport source (output valid, output char_address, output row_address, output hsync,
                    output vsync, output display_enable, output cursor, output blink_phase,
                    output read_data, input ready);
    modport sink (input valid, input char_address, input row_address, input hsync,
                  input vsync, input display_enable, input cursor, input blink_phase,
                  input read_data, output ready);
endinterface

interface crtc_cfg_if;
    logic valid;
    logic ready;
    logic data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ src/crt_raster_timing_controller.sv @@
// Top level of the raster timing controller: handshakes around the timing core.
//
// One command transaction enters on the item channel (cmd, data) and yields
// exactly one result transaction on the result channel: memory address, scan
// line, syncs, skewed display enable and cursor, blink phase and read data.
// The command is processed in one pass from the accepted item into the result
// register, so the result is offered in the cycle after acceptance. A new command
// is accepted every cycle while the result register is empty or being taken;
// the single result register sets that throughput of one item per cycle.
// When the receiver stalls, the result is held and ready drops until it is
// taken. The configuration channel writes the start-address read enable and
// is always ready. Reset clears the register file, counters and all pending
// delays, and leaves the result channel empty.
`default_nettype none
module crt_raster_timing_controller
    import crtc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    crtc_item_if.sink     in_ch,
    crtc_result_if.source out_ch,
    crtc_cfg_if.sink      cfg
);

    logic    full_reg;
    logic    readable_reg;
    logic    step;
    item_t   item;
    result_t res;

    assign in_ch.ready = !full_reg || out_ch.ready;
    assign step = in_ch.valid && in_ch.ready;
    assign item = '{cmd: in_ch.cmd, data: in_ch.data};
    assign cfg.ready = 1'b1;

    // Output valid and configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
            readable_reg <= 1'b0;
        end
        else
        begin
            if (step) full_reg <= 1'b1;
            else if (out_ch.ready) full_reg <= 1'b0;
            if (cfg.valid) readable_reg <= cfg.data;
        end
    end

    crtc_core u_core (
        .clk(clk), .rst_n(rst_n), .step(step), .item(item),
        .start_readable(readable_reg), .result(res)
    );

    assign out_ch.valid = full_reg;
    assign out_ch.char_address = res.char_address;
    assign out_ch.row_address = res.row_address;
    assign out_ch.hsync = res.hsync;
    assign out_ch.vsync = res.vsync;
    assign out_ch.display_enable = res.display_enable;
    assign out_ch.cursor = res.cursor;
    assign out_ch.blink_phase = res.blink_phase;
    assign out_ch.read_data = res.read_data;

    // A stalled result stays offered.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("result dropped");
    // An accepted item always produces a result.
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_ch.valid) else $error("result missing");
    // No input is taken while a stalled result waits.
    a_block: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg && !out_ch.ready |-> !in_ch.ready) else $error("overrun");

endmodule
`default_nettype wire

@@ src/crtc_core.sv @@
// Timing state and the single-pass update for one command.
`default_nettype none
module crtc_core
    import crtc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    step,
    input  wire item_t   item,
    input  wire logic    start_readable,
    output result_t      result
);

    logic [7:0]  regs_reg [18];
    logic [7:0]  regs_next [18];
    logic [4:0]  sel_reg, sel_next;
    logic [7:0]  col_reg, col_next;
    logic        colw_reg, colw_next;
    logic [4:0]  line_reg, line_next;
    logic        linew_reg, linew_next;
    logic [6:0]  row_reg, row_next;
    logic        roww_reg, roww_next;
    logic [3:0]  hcnt_reg, hcnt_next;
    logic [4:0]  vcnt_reg, vcnt_next;
    logic [4:0]  vlines_reg, vlines_next;
    logic        hs_reg, hs_next, vs_reg, vs_next;
    logic        adj_reg, adj_next;
    logic [4:0]  acnt_reg, acnt_next;
    logic [13:0] addr_reg, addr_next, base_reg, base_next, nrow_reg, nrow_next;
    logic        hen_reg, hen_next, ven_reg, ven_next;
    logic        deraw_reg, deraw_next, deout_reg, deout_next;
    logic        curon_reg, curon_next;
    logic [5:0]  blink_reg, blink_next;
    logic [3:0]  pend_reg, pend_next;
    logic [2:0]  cskew_reg, cskew_next, donsk_reg, donsk_next, doffsk_reg, doffsk_next;
    logic [7:0]  rd;

    // Skew values are kept as 3-bit two's complement so -1 can be held.
    always_comb
    begin
        logic [13:0] sa, ca;
        logic [1:0]  skew;
        logic        nx;
        logic [7:0]  v;
        for (int i = 0; i < 18; i++) regs_next[i] = regs_reg[i];
        sel_next = sel_reg; col_next = col_reg; colw_next = colw_reg;
        line_next = line_reg; linew_next = linew_reg; row_next = row_reg;
        roww_next = roww_reg; hcnt_next = hcnt_reg; vcnt_next = vcnt_reg;
        vlines_next = vlines_reg; hs_next = hs_reg; vs_next = vs_reg;
        adj_next = adj_reg; acnt_next = acnt_reg; addr_next = addr_reg;
        base_next = base_reg; nrow_next = nrow_reg; hen_next = hen_reg;
        ven_next = ven_reg; deraw_next = deraw_reg; deout_next = deout_reg;
        curon_next = curon_reg; blink_next = blink_reg; pend_next = pend_reg;
        cskew_next = cskew_reg; donsk_next = donsk_reg; doffsk_next = doffsk_reg;
        rd = 8'd0;
        sa = {regs_reg[REG_STARTH][5:0], regs_reg[REG_STARTL]};
        ca = {regs_reg[REG_CURH][5:0], regs_reg[REG_CURL]};
        skew = regs_reg[REG_MODE][5:4];
        v = item.data[7:0];
        nx = 1'b0;

        unique case (item.cmd)
            CMD_CHAR:
            begin
                addr_next = addr_reg + 14'd1;
                col_next = col_reg + 8'd1;
                if (colw_reg)
                begin
                    col_next = 8'd0;
                    colw_next = 1'b0;
                    hen_next = 1'b1;
                    // Enable update, horizontal start of line.
                    nx = hen_next && ven_next;
                    if (nx && !deraw_next)
                    begin
                        donsk_next = {1'b0, skew};
                        if (skew != 2'd3) pend_next[2] = 1'b1;
                    end
                    if (!nx && deraw_next)
                    begin
                        doffsk_next = {1'b0, skew};
                        pend_next[3] = 1'b1;
                    end
                    deraw_next = nx;
                    addr_next = base_reg;
                    line_next = line_reg + 5'd1;
                    if (adj_reg) acnt_next = acnt_reg + 5'd1;
                    if (vs_reg) vcnt_next = vcnt_reg + 5'd1;
                    if (linew_reg)
                    begin
                        line_next = 5'd0;
                        linew_next = 1'b0;
                        base_next = nrow_reg;
                        addr_next = nrow_reg;
                        row_next = row_reg + 7'd1;
                        if (roww_reg)
                        begin
                            roww_next = 1'b0;
                            if (regs_reg[REG_VADJ] != 8'd0)
                            begin
                                adj_next = 1'b1;
                                acnt_next = 5'd0;
                            end
                            else
                            begin
                                line_next = 5'd0;
                                row_next = 7'd0;
                                ven_next = 1'b1;
                                nx = hen_next;
                                if (nx && !deraw_next)
                                begin
                                    donsk_next = {1'b0, skew};
                                    if (skew != 2'd3) pend_next[2] = 1'b1;
                                end
                                deraw_next = nx;
                                addr_next = sa;
                                base_next = sa;
                                nrow_next = sa;
                            end
                        end
                        if ({1'b0, row_next} == regs_reg[REG_VTOTAL] && !adj_next)
                            roww_next = 1'b1;
                        if ({1'b0, row_next} == regs_reg[REG_VDISP])
                        begin
                            ven_next = 1'b0;
                            if (deraw_next)
                            begin
                                doffsk_next = {1'b0, skew};
                                pend_next[3] = 1'b1;
                            end
                            deraw_next = 1'b0;
                        end
                        if ({1'b0, row_next} == regs_reg[REG_VSPOS]) vs_next = 1'b1;
                    end
                    if (vs_next && vcnt_next == vlines_reg)
                    begin
                        vcnt_next = 5'd0;
                        vs_next = 1'b0;
                    end
                    if (adj_next && {3'd0, acnt_next} == regs_reg[REG_VADJ])
                    begin
                        adj_next = 1'b0;
                        acnt_next = 5'd0;
                        line_next = 5'd0;
                        row_next = 7'd0;
                        ven_next = 1'b1;
                        nx = hen_next;
                        if (nx && !deraw_next)
                        begin
                            donsk_next = {1'b0, skew};
                            if (skew != 2'd3) pend_next[2] = 1'b1;
                        end
                        deraw_next = nx;
                        addr_next = sa;
                        base_next = sa;
                        nrow_next = sa;
                        if (regs_reg[REG_VSPOS] == 8'd0) vs_next = 1'b1;
                    end
                    if ({3'd0, line_next} == regs_reg[REG_MAXLINE]) linew_next = 1'b1;
                end
                if (col_next == regs_reg[REG_HTOTAL]) colw_next = 1'b1;
                if (col_next == regs_reg[REG_HDISP])
                begin
                    nrow_next = addr_next;
                    hen_next = 1'b0;
                    if (deraw_next)
                    begin
                        doffsk_next = {1'b0, skew};
                        pend_next[3] = 1'b1;
                    end
                    deraw_next = 1'b0;
                end
                if (hs_next) hcnt_next = hcnt_next + 4'd1;
                if (col_next == regs_reg[REG_HSPOS] && regs_reg[REG_SYNCW][3:0] != 4'd0)
                    hs_next = 1'b1;
                if (hs_next && hcnt_next == regs_reg[REG_SYNCW][3:0])
                begin
                    hcnt_next = 4'd0;
                    hs_next = 1'b0;
                end
                // Cursor match starts its skew delay.
                if (addr_next == ca && line_next >= regs_reg[REG_CURSTART][4:0]
                    && {3'd0, line_next} <= regs_reg[REG_CUREND] && deraw_next)
                begin
                    cskew_next = {1'b0, regs_reg[REG_MODE][7:6]};
                    if (regs_reg[REG_MODE][7:6] != 2'd3) pend_next[0] = 1'b1;
                end
                if (pend_next[1])
                begin
                    pend_next[1] = 1'b0;
                    curon_next = 1'b0;
                end
                if (pend_next[0])
                begin
                    if (!cskew_next[2]) cskew_next = cskew_next - 3'd1;
                    if (cskew_next[2] && (regs_reg[REG_CURSTART][6:0] & CurModeMsk) != CurModeOff)
                    begin
                        pend_next[0] = 1'b0;
                        pend_next[1] = 1'b1;
                        curon_next = 1'b1;
                    end
                end
                if (pend_next[2])
                begin
                    donsk_next = donsk_next - 3'd1;
                    if (donsk_next[2])
                    begin
                        pend_next[2] = 1'b0;
                        donsk_next = 3'd0;
                        deout_next = 1'b1;
                    end
                end
                if (pend_next[3])
                begin
                    doffsk_next = doffsk_next - 3'd1;
                    if (doffsk_next[2])
                    begin
                        pend_next[3] = 1'b0;
                        doffsk_next = 3'd0;
                        deout_next = 1'b0;
                    end
                end
            end
            CMD_FRAME:
                blink_next = (blink_reg == BlinkWrap) ? 6'd0 : blink_reg + 6'd1;
            CMD_SELECT:
                sel_next = item.data[4:0];
            CMD_WRITE:
            begin
                unique case (sel_reg)
                    REG_HTOTAL, REG_HDISP, REG_HSPOS, REG_CURL, REG_STARTL:
                        regs_next[sel_reg] = v;
                    REG_SYNCW:
                    begin
                        vlines_next = (v[7:4] == 4'd0) ? 5'd16 : {1'b0, v[7:4]};
                        regs_next[REG_SYNCW] = v;
                    end
                    REG_VTOTAL, REG_VDISP, REG_VSPOS, REG_CURSTART:
                        regs_next[sel_reg] = {1'b0, v[6:0]};
                    REG_VADJ, REG_MAXLINE, REG_CUREND:
                        regs_next[sel_reg] = {3'd0, v[4:0]};
                    REG_MODE:
                        regs_next[REG_MODE] = v & 8'hf3;
                    REG_STARTH, REG_CURH:
                        regs_next[sel_reg] = {2'd0, v[5:0]};
                    default: ;
                endcase
            end
            CMD_READ:
            begin
                unique case (sel_reg)
                    REG_STARTH, REG_STARTL:
                        rd = start_readable ? regs_reg[sel_reg] : 8'd0;
                    REG_CURH, REG_CURL, REG_PENH, REG_PENL:
                        rd = regs_reg[sel_reg];
                    default: rd = 8'd0;
                endcase
            end
            CMD_LOAD:
            begin
                addr_next = item.data;
                base_next = item.data;
                nrow_next = item.data;
            end
            default: ;
        endcase
    end

    // Register file has no reset dependency beyond clearing.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 18; i++) regs_reg[i] <= 8'd0;
            sel_reg <= '0; col_reg <= '0; colw_reg <= 1'b1; line_reg <= '0;
            linew_reg <= 1'b1; row_reg <= '0; roww_reg <= 1'b1; hcnt_reg <= '0;
            vcnt_reg <= '0; vlines_reg <= '0; hs_reg <= 1'b0; vs_reg <= 1'b0;
            adj_reg <= 1'b0; acnt_reg <= '0; addr_reg <= '0; base_reg <= '0;
            nrow_reg <= '0; hen_reg <= 1'b0; ven_reg <= 1'b0; deraw_reg <= 1'b0;
            deout_reg <= 1'b0; curon_reg <= 1'b0; blink_reg <= '0; pend_reg <= '0;
            cskew_reg <= '0; donsk_reg <= '0; doffsk_reg <= '0;
            result <= '0;
        end
        else if (step)
        begin
            for (int i = 0; i < 18; i++) regs_reg[i] <= regs_next[i];
            sel_reg <= sel_next; col_reg <= col_next; colw_reg <= colw_next;
            line_reg <= line_next; linew_reg <= linew_next; row_reg <= row_next;
            roww_reg <= roww_next; hcnt_reg <= hcnt_next; vcnt_reg <= vcnt_next;
            vlines_reg <= vlines_next; hs_reg <= hs_next; vs_reg <= vs_next;
            adj_reg <= adj_next; acnt_reg <= acnt_next; addr_reg <= addr_next;
            base_reg <= base_next; nrow_reg <= nrow_next; hen_reg <= hen_next;
            ven_reg <= ven_next; deraw_reg <= deraw_next; deout_reg <= deout_next;
            curon_reg <= curon_next; blink_reg <= blink_next; pend_reg <= pend_next;
            cskew_reg <= cskew_next; donsk_reg <= donsk_next; doffsk_reg <= doffsk_next;
            result.char_address <= addr_next;
            result.row_address <= line_next;
            result.hsync <= hs_next;
            result.vsync <= vs_next;
            result.display_enable <= deout_next;
            result.cursor <= curon_next;
            result.blink_phase <= (blink_next > BlinkHalf);
            result.read_data <= rd;
        end
    end

    // The blink counter never leaves its modulo range.
    a_blink_range: assert property (@(posedge clk) disable iff (!rst_n)
        blink_reg <= BlinkWrap) else $error("blink count out of range");
    // A write never changes the light pen bytes.
    a_pen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        regs_reg[REG_PENH] == 8'd0 && regs_reg[REG_PENL] == 8'd0)
        else $error("light pen byte written");
    // A load sets the reported address on the next edge.
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.cmd == CMD_LOAD |=> result.char_address == $past(item.data))
        else $error("address load lost");

endmodule
`default_nettype wire
